// ===== rtl/btn_rpt_pkg.sv =====
package btn_rpt_pkg;

	localparam int NUM_BUTTONS = 64;
	localparam int MASK_W      = 64;
	localparam int TICK_W      = 16;
	localparam int BID_W       = 7;
	localparam int IDX_W       = 6;

	// buttons that exist; higher bits of held/enable masks are ignored
	localparam logic [MASK_W-1:0] BTN_MASK = {MASK_W{1'b1}} >> (MASK_W - NUM_BUTTONS);

	typedef enum logic [1:0] {
		CMD_PRESS   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_TICK    = 2'd2
	} cmd_code_t;

	typedef struct packed {
		logic capture;
		logic press;
		logic release_btn;
		logic tick_count;
		logic tick_fire;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      id_ok;
		logic      live_any;
		logic      hit;
		logic      out_free;
		logic      scan_last;
		logic      scan_empty;
	} dp_status_t;

endpackage

// ===== rtl/btn_rpt_dp.sv =====
module btn_rpt_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  btn_rpt_pkg::dp_cmd_t              ctl,
	output btn_rpt_pkg::dp_status_t           status,
	input  logic [1:0]                        cmd,
	input  logic [btn_rpt_pkg::BID_W-1:0]     button_id,
	input  logic [btn_rpt_pkg::MASK_W-1:0]    cfg_mask,
	input  logic [btn_rpt_pkg::TICK_W-1:0]    cfg_delay,
	input  logic [btn_rpt_pkg::TICK_W-1:0]    cfg_rate,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [btn_rpt_pkg::BID_W-1:0]     button_report,
	output logic                              last
);

	logic [1:0]                        cmd_q;
	logic [btn_rpt_pkg::BID_W-1:0]     id_q;
	logic [btn_rpt_pkg::MASK_W-1:0]    held_q;
	logic [btn_rpt_pkg::TICK_W-1:0]    elapsed_q;
	logic                              delay_q;
	logic [btn_rpt_pkg::MASK_W-1:0]    scan_q;
	logic                              out_valid_q;
	logic [btn_rpt_pkg::BID_W-1:0]     report_q;
	logic                              last_q;

	logic [btn_rpt_pkg::IDX_W-1:0]     idx;
	logic [btn_rpt_pkg::MASK_W-1:0]    press_bit;
	logic                              press_en;
	logic [btn_rpt_pkg::MASK_W-1:0]    live;
	logic [btn_rpt_pkg::TICK_W-1:0]    inc;
	logic [btn_rpt_pkg::TICK_W-1:0]    threshold;
	logic [btn_rpt_pkg::MASK_W-1:0]    low_bit;
	logic [btn_rpt_pkg::MASK_W-1:0]    scan_rest;
	logic [btn_rpt_pkg::IDX_W-1:0]     low_idx;
	logic                              out_free;

	assign idx       = btn_rpt_pkg::IDX_W'(id_q - btn_rpt_pkg::BID_W'(1));
	assign press_bit = btn_rpt_pkg::MASK_W'(1) << idx;
	assign press_en  = cfg_mask[idx];
	assign live      = held_q & btn_rpt_pkg::BTN_MASK;

	// saturating count, compared against the phase threshold
	assign inc       = (elapsed_q == {btn_rpt_pkg::TICK_W{1'b1}}) ? elapsed_q
	                 : elapsed_q + btn_rpt_pkg::TICK_W'(1);
	assign threshold = delay_q ? cfg_delay : cfg_rate;

	// lowest pending button of the burst
	assign low_bit   = scan_q & (~scan_q + btn_rpt_pkg::MASK_W'(1));
	assign scan_rest = scan_q & (scan_q - btn_rpt_pkg::MASK_W'(1));

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < btn_rpt_pkg::MASK_W; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | btn_rpt_pkg::IDX_W'(i);
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign status.cmd        = btn_rpt_pkg::cmd_code_t'(cmd_q);
	assign status.id_ok      = (id_q != '0) &&
	                           (id_q <= btn_rpt_pkg::BID_W'(btn_rpt_pkg::NUM_BUTTONS));
	assign status.live_any   = (live != '0);
	assign status.hit        = (inc >= threshold);
	assign status.out_free   = out_free;
	assign status.scan_last  = (scan_rest == '0);
	assign status.scan_empty = (scan_q == '0);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd;
			id_q  <= button_id;
		end
		if (ctl.press) begin
			report_q <= id_q;
			last_q   <= 1'b1;
		end else if (ctl.emit) begin
			report_q <= btn_rpt_pkg::BID_W'(low_idx) + btn_rpt_pkg::BID_W'(1);
			last_q   <= (scan_rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			elapsed_q   <= '0;
			delay_q     <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.press && press_en) begin
				held_q    <= held_q | press_bit;
				elapsed_q <= '0;
				delay_q   <= 1'b1;
			end else if (ctl.release_btn) begin
				held_q <= held_q & ~press_bit;
			end else if (ctl.tick_count) begin
				elapsed_q <= inc;
			end else if (ctl.tick_fire) begin
				elapsed_q <= '0;
				delay_q   <= 1'b0;
			end

			if (ctl.tick_fire) begin
				scan_q <= live;
			end else if (ctl.emit) begin
				scan_q <= scan_rest;
			end

			if (ctl.press || ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign button_report = report_q;
	assign last          = last_q;

endmodule

// ===== rtl/btn_rpt_ctrl.sv =====
module btn_rpt_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  btn_rpt_pkg::dp_status_t  status,
	output btn_rpt_pkg::dp_cmd_t     ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_BURST
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   stall_q;

	always_comb begin
		ctl = '0;
		nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					nxt         = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (status.cmd)
					btn_rpt_pkg::CMD_PRESS: begin
						if (!status.id_ok) begin
							nxt = ST_IDLE;
						end else if (status.out_free) begin
							ctl.press = 1'b1;
							nxt       = ST_IDLE;
						end
					end
					btn_rpt_pkg::CMD_RELEASE: begin
						ctl.release_btn = status.id_ok;
						nxt             = ST_IDLE;
					end
					btn_rpt_pkg::CMD_TICK: begin
						if (!status.live_any) begin
							nxt = ST_IDLE;
						end else if (status.hit) begin
							ctl.tick_fire = 1'b1;
							nxt           = ST_BURST;
						end else begin
							ctl.tick_count = 1'b1;
							nxt            = ST_IDLE;
						end
					end
					default: begin
						nxt = ST_IDLE;
					end
				endcase
			end
			ST_BURST: begin
				if (status.out_free) begin
					ctl.emit = 1'b1;
					if (status.scan_last) begin
						nxt = ST_IDLE;
					end
				end
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= nxt;
			stall_q <= (nxt != ST_IDLE);
		end
	end

	assign in_stall = stall_q;

endmodule

// ===== rtl/button_auto_repeat_generator_core.sv =====
// Press/release/tick words: stall rises in the cycle after each accepted word.
// A press report goes out on out_valid after the execute state, once the output is free;
// a firing tick loads the held buttons into the burst mask, then one report per cycle
// follows while the output is free; presses and bursts wait while out_stall is high.
// Reset (arst_n low) clears held buttons, tick count, phase, output valid and loads
// enable mask 0, delay 500, rate 50.
module button_auto_repeat_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic [btn_rpt_pkg::BID_W-1:0]     button_id,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [btn_rpt_pkg::BID_W-1:0]     button_report,
	output logic                              last,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [4:0]                        paddr,
	input  logic [63:0]                       pwdata,
	output logic [63:0]                       prdata,
	output logic                              pready
);

	localparam logic [1:0] REG_MASK  = 2'd0;
	localparam logic [1:0] REG_DELAY = 2'd1;
	localparam logic [1:0] REG_RATE  = 2'd2;

	logic [btn_rpt_pkg::MASK_W-1:0] mask_q;
	logic [btn_rpt_pkg::TICK_W-1:0] delay_q;
	logic [btn_rpt_pkg::TICK_W-1:0] rate_q;
	logic                           wr_en;
	logic [1:0]                     reg_sel;

	btn_rpt_pkg::dp_cmd_t    ctl;
	btn_rpt_pkg::dp_status_t status;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			delay_q <= btn_rpt_pkg::TICK_W'(500);
			rate_q  <= btn_rpt_pkg::TICK_W'(50);
		end else if (wr_en) begin
			case (reg_sel)
				REG_MASK:  mask_q  <= pwdata;
				REG_DELAY: delay_q <= pwdata[btn_rpt_pkg::TICK_W-1:0];
				REG_RATE:  rate_q  <= pwdata[btn_rpt_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MASK:  prdata = mask_q;
			REG_DELAY: prdata = 64'(delay_q);
			REG_RATE:  prdata = 64'(rate_q);
			default:   prdata = '0;
		endcase
	end

	btn_rpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	btn_rpt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.status        (status),
		.cmd           (cmd),
		.button_id     (button_id),
		.cfg_mask      (mask_q),
		.cfg_delay     (delay_q),
		.cfg_rate      (rate_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.button_report (button_report),
		.last          (last)
	);

`ifndef SYNTH
	// no burst left over once the block is ready for a new word
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> status.scan_empty)
		else $error("burst mask not empty while ready");

	// reports always name an existing button
	a_report_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (button_report != '0) &&
		(button_report <= btn_rpt_pkg::BID_W'(btn_rpt_pkg::NUM_BUTTONS)))
		else $error("report id out of range");

	// stall only rises after a word was taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("stall raised without an accepted word");
`endif

endmodule
